@@ rtl/core/ccxc_pkg.sv @@
// ----------------------------------------------------------------------------
// Cyrillic case transcoder package
// Shared types, code constants and the byte conversion functions used by
// the front end, the word queue and the back end.
// ----------------------------------------------------------------------------
package ccxc_pkg;

   // Encoding mode register codes. Code 3 behaves as the plain single-byte mode.
   localparam logic [1:0] MODE_UTF8     = 2'd0;
   localparam logic [1:0] MODE_SB_CASE  = 2'd1;
   localparam logic [1:0] MODE_SB_PLAIN = 2'd2;

   // UTF-8 Cyrillic lead bytes and tails.
   localparam logic [7:0] LEAD_LO      = 8'hD0;
   localparam logic [7:0] LEAD_HI      = 8'hD1;
   localparam logic [7:0] CASE_DELTA   = 8'h20;
   localparam logic [7:0] YO_UP_TAIL   = 8'h81;
   localparam logic [7:0] YO_LO_TAIL   = 8'h91;

   // Single-byte code page values.
   localparam logic [7:0] CP_A_UP      = 8'd192;
   localparam logic [7:0] CP_YA_UP     = 8'd223;
   localparam logic [7:0] CP_A_LO      = 8'd224;
   localparam logic [7:0] CP_PAGE_HI   = 8'd240;
   localparam logic [7:0] CP_OFF_LO    = 8'd48;
   localparam logic [7:0] CP_OFF_HI    = 8'd112;
   localparam logic [7:0] CP_YO_UP     = 8'd168;
   localparam logic [7:0] CP_YO_LO     = 8'd184;

   // One queued unit of work: one or two output bytes of a single input word.
   typedef struct packed {
      logic       pair;
      logic [7:0] b0;
      logic [7:0] b1;
      logic       str_end;
   } entry_type;

   // Queue status seen by the front and back ends.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
   } byte_pair_type;

   function automatic logic [7:0] ascii_case(input logic [7:0] c, input logic up);
      logic [7:0] r;
      r = c;
      if (up) begin
         if (c >= 8'h61 && c <= 8'h7A) r = c - CASE_DELTA;
      end else begin
         if (c >= 8'h41 && c <= 8'h5A) r = c + CASE_DELTA;
      end
      return r;
   endfunction

   // Re-case a two-byte Cyrillic sequence; pairs without a case partner pass.
   function automatic byte_pair_type recase_pair(input logic [7:0] s1,
                                                 input logic [7:0] s2,
                                                 input logic up);
      byte_pair_type r;
      r.b0 = s1;
      r.b1 = s2;
      if (!up) begin
         if (s1 == LEAD_LO && s2 >= 8'h90 && s2 <= 8'h9F) begin
            r.b0 = LEAD_LO;
            r.b1 = s2 + CASE_DELTA;
         end else if (s1 == LEAD_LO && s2 >= 8'hA0 && s2 <= 8'hAF) begin
            r.b0 = LEAD_HI;
            r.b1 = s2 - CASE_DELTA;
         end else if (s1 == LEAD_LO && s2 == YO_UP_TAIL) begin
            r.b0 = LEAD_HI;
            r.b1 = YO_LO_TAIL;
         end
      end else begin
         if (s1 == LEAD_HI && s2 >= 8'h80 && s2 <= 8'h8F) begin
            r.b0 = LEAD_LO;
            r.b1 = s2 + CASE_DELTA;
         end else if (s1 == LEAD_LO && s2 >= 8'hB0 && s2 <= 8'hBF) begin
            r.b0 = LEAD_LO;
            r.b1 = s2 - CASE_DELTA;
         end else if (s1 == LEAD_HI && s2 == YO_LO_TAIL) begin
            r.b0 = LEAD_LO;
            r.b1 = YO_UP_TAIL;
         end
      end
      return r;
   endfunction

   // Single-byte code page to UTF-8; ASCII is always re-cased, Cyrillic only with do_case.
   function automatic entry_type sb_convert(input logic [7:0] c_in,
                                            input logic       do_case,
                                            input logic       up,
                                            input logic       str_end);
      entry_type  e;
      logic [7:0] c;
      c         = c_in;
      e.pair    = 1'b0;
      e.b0      = c_in;
      e.b1      = '0;
      e.str_end = str_end;
      if (c_in < 8'h80) begin
         e.b0 = ascii_case(c_in, up);
      end else begin
         if (do_case) begin
            if (!up) begin
               if (c >= CP_A_UP && c <= CP_YA_UP) c = c + CASE_DELTA;
               else if (c == CP_YO_UP)            c = CP_YO_LO;
            end else begin
               if (c >= CP_A_LO)        c = c - CASE_DELTA;
               else if (c == CP_YO_LO)  c = CP_YO_UP;
            end
         end
         if (c >= CP_A_UP) begin
            e.pair = 1'b1;
            e.b0   = (c < CP_PAGE_HI) ? LEAD_LO : LEAD_HI;
            e.b1   = (c < CP_PAGE_HI) ? (c - CP_OFF_LO) : (c - CP_OFF_HI);
         end else if (c == CP_YO_LO) begin
            e.pair = 1'b1;
            e.b0   = LEAD_HI;
            e.b1   = YO_LO_TAIL;
         end else if (c == CP_YO_UP) begin
            e.pair = 1'b1;
            e.b0   = LEAD_LO;
            e.b1   = YO_UP_TAIL;
         end else begin
            e.b0 = c;
         end
      end
      return e;
   endfunction

endpackage

@@ rtl/core/ccxc_front.sv @@
// ----------------------------------------------------------------------------
// Cyrillic case transcoder front end
// Accepts input words, tracks the UTF-8 sequence state and turns each word
// that produces output into a queue entry of one or two output bytes.
// ----------------------------------------------------------------------------
module ccxc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_encoding_mode,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_to_upper,
   input  logic                 req_string_end,
   input  ccxc_pkg::qstat_type  qstat,
   output logic                 push,
   output ccxc_pkg::entry_type  push_entry
);
   import ccxc_pkg::*;

   logic [1:0]    mode_ff;
   logic          lead_pending_ff, lead_pending_in;
   logic          lead_hi_ff, lead_hi_in;
   logic [1:0]    pass_left_ff, pass_left_in;
   logic          has_out;
   logic          take;
   entry_type     ent;
   byte_pair_type rp;

   assign req_stall = qstat.full;
   assign take      = req_valid && !qstat.full;

   always_comb begin
      lead_pending_in = lead_pending_ff;
      lead_hi_in      = lead_hi_ff;
      pass_left_in    = pass_left_ff;
      has_out         = 1'b1;
      ent.pair        = 1'b0;
      ent.b0          = req_data_byte;
      ent.b1          = '0;
      ent.str_end     = req_string_end;
      rp = recase_pair(lead_hi_ff ? LEAD_HI : LEAD_LO, req_data_byte, req_to_upper);
      if (mode_ff == MODE_UTF8) begin
         if (lead_pending_ff) begin
            ent.pair        = 1'b1;
            ent.b0          = rp.b0;
            ent.b1          = rp.b1;
            lead_pending_in = 1'b0;
            lead_hi_in      = 1'b0;
         end else if (pass_left_ff != 2'd0) begin
            pass_left_in = pass_left_ff - 2'd1;
         end else if (req_data_byte < 8'h80) begin
            ent.b0 = ascii_case(req_data_byte, req_to_upper);
         end else if (req_data_byte == LEAD_LO || req_data_byte == LEAD_HI) begin
            // A lead on the last byte of a string goes out alone.
            if (!req_string_end) begin
               has_out         = 1'b0;
               lead_pending_in = 1'b1;
               lead_hi_in      = (req_data_byte == LEAD_HI);
            end
         end else if ((req_data_byte & 8'hE0) == 8'hC0) begin
            pass_left_in = 2'd1;
         end else if ((req_data_byte & 8'hF0) == 8'hE0) begin
            pass_left_in = 2'd2;
         end else begin
            pass_left_in = 2'd3;
         end
         if (req_string_end) begin
            lead_pending_in = 1'b0;
            lead_hi_in      = 1'b0;
            pass_left_in    = 2'd0;
         end
      end else begin
         lead_pending_in = 1'b0;
         lead_hi_in      = 1'b0;
         pass_left_in    = 2'd0;
         ent = sb_convert(req_data_byte, mode_ff == MODE_SB_CASE, req_to_upper,
                          req_string_end);
      end
   end

   assign push       = take && has_out;
   assign push_entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_UTF8;
         lead_pending_ff <= 1'b0;
         lead_hi_ff      <= 1'b0;
         pass_left_ff    <= 2'd0;
      end else if (csr_write_enable) begin
         mode_ff         <= csr_encoding_mode;
         lead_pending_ff <= 1'b0;
         lead_hi_ff      <= 1'b0;
         pass_left_ff    <= 2'd0;
      end else if (take) begin
         lead_pending_ff <= lead_pending_in;
         lead_hi_ff      <= lead_hi_in;
         pass_left_ff    <= pass_left_in;
      end
   end

endmodule

@@ rtl/core/ccxc_queue.sv @@
// ----------------------------------------------------------------------------
// Cyrillic case transcoder word queue
// Small first-in first-out buffer of entries between front and back end.
// ----------------------------------------------------------------------------
module ccxc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ccxc_pkg::entry_type  push_entry,
   input  logic                 pop,
   output ccxc_pkg::entry_type  pop_entry,
   output ccxc_pkg::qstat_type  qstat
);
   import ccxc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = PTR_W + 1;

   entry_type          slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push;
   logic               do_pop;

   assign qstat.full  = (count_ff == CNT_W'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign pop_entry   = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Pointers wrap at the last slot, so any depth works.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop)      count_ff <= count_ff + CNT_W'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - CNT_W'(1);
      end
   end

endmodule

@@ rtl/core/ccxc_back.sv @@
// ----------------------------------------------------------------------------
// Cyrillic case transcoder back end
// Drains queue entries into the output register, one byte per word.
// ----------------------------------------------------------------------------
module ccxc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ccxc_pkg::qstat_type  qstat,
   input  ccxc_pkg::entry_type  pop_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_run_last,
   output logic                 rsp_string_last
);
   import ccxc_pkg::*;

   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_run_last_ff;
   logic       rsp_str_last_ff;
   logic       sec_valid_ff;
   logic [7:0] sec_byte_ff;
   logic       sec_end_ff;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = out_free && !sec_valid_ff && !qstat.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (sec_valid_ff) begin
            rsp_valid_ff <= 1'b1;
            sec_valid_ff <= 1'b0;
         end else if (!qstat.empty) begin
            rsp_valid_ff <= 1'b1;
            sec_valid_ff <= pop_entry.pair;
         end else begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (sec_valid_ff) begin
            rsp_byte_ff     <= sec_byte_ff;
            rsp_run_last_ff <= 1'b1;
            rsp_str_last_ff <= sec_end_ff;
         end else if (!qstat.empty) begin
            rsp_byte_ff     <= pop_entry.b0;
            rsp_run_last_ff <= !pop_entry.pair;
            rsp_str_last_ff <= pop_entry.str_end && !pop_entry.pair;
            sec_byte_ff     <= pop_entry.b1;
            sec_end_ff      <= pop_entry.str_end;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_run_last    = rsp_run_last_ff;
   assign rsp_string_last = rsp_str_last_ff;

endmodule

@@ rtl/core/cyrillic_case_transcoder.sv @@
// Path: a word's bytes pass through the word queue and the output register;
// a held Cyrillic lead yields its bytes with the next word.
// Throughput: one input word per cycle; a two-byte word holds the output for both
// its bytes, the word queue absorbs this and the input stalls only while it is full.
// Reset: synchronous, active high; clears the mode to UTF-8, the sequence
// state, the word queue and the output register.
// ----------------------------------------------------------------------------
// Cyrillic case transcoder
// Converts a byte stream to UTF-8 with case folding of ASCII and Cyrillic.
// ----------------------------------------------------------------------------
module cyrillic_case_transcoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   // Configuration register write port
   input  logic       csr_write_enable,
   input  logic [1:0] csr_encoding_mode,
   // Input word channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_to_upper,
   input  logic       req_string_end,
   // Output word channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_string_last
);
   import ccxc_pkg::*;

   // The front end classifies every accepted word against the current
   // sequence state (held Cyrillic lead, continuation bytes left) and builds
   // one queue entry holding all output bytes that word produces. Words that
   // produce nothing, such as a held lead, leave no entry.
   qstat_type qstat;
   entry_type push_entry;
   entry_type pop_entry;
   logic      push;
   logic      pop;

   ccxc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_encoding_mode (csr_encoding_mode),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_to_upper      (req_to_upper),
      .req_string_end    (req_string_end),
      .qstat             (qstat),
      .push              (push),
      .push_entry        (push_entry)
   );

   // The queue decouples the two sides: the input keeps flowing while the
   // back end emits the second byte of a two-byte entry, and the input only
   // stalls once the queue has filled up.
   ccxc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .qstat      (qstat)
   );

   // The back end emits the bytes of each entry in order through a registered
   // output, flagging the last byte of each word and of each string.
   ccxc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .qstat           (qstat),
      .pop_entry       (pop_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_last (rsp_string_last)
   );

endmodule

@@ rtl/core/ccxc_checker.sv @@
// ----------------------------------------------------------------------------
// Cyrillic case transcoder port checker
// Watches the top level ports over time and flags illegal behavior.
// ----------------------------------------------------------------------------
module ccxc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_string_last
);

   // A stalled output word holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_run_last) && $stable(rsp_string_last))
   else $error("stalled output word changed");

   // The end of a string is always the last byte of its word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_last |-> rsp_run_last)
   else $error("string end flagged before end of word");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
   else $error("output valid after reset");

   // Reset empties the queue, so the input is open right after it.
   assert property (@(posedge clock) reset |=> !req_stall)
   else $error("input stalled after reset");

endmodule

bind cyrillic_case_transcoder ccxc_checker u_ccxc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_run_last    (rsp_run_last),
   .rsp_string_last (rsp_string_last)
);
